>>> sv/msps_pkg.sv
`timescale 1ns / 1ps
package msps_pkg;

  // path count and derived widths
  localparam int MAX_PATHS = 8;
  localparam int IDX_W     = 8;
  localparam int RSN_W     = 3;
  localparam int LIMIT_W   = 8;

  localparam logic [IDX_W-1:0] MAX_PATHS_IDX = IDX_W'(MAX_PATHS);
  localparam logic [IDX_W-1:0] IDX_ONE       = IDX_W'(1);
  localparam logic [IDX_W-1:0] CONTROL_INDEX = IDX_W'(255);

  // reset value of the repeat limit register
  localparam logic [LIMIT_W-1:0] REPEAT_LIMIT_RESET = LIMIT_W'(3);

  // reason codes
  localparam logic [RSN_W-1:0] RSN_NONE      = 3'd0;
  localparam logic [RSN_W-1:0] RSN_CHALLENGE = 3'd1;
  localparam logic [RSN_W-1:0] RSN_RESPONSE  = 3'd2;
  localparam logic [RSN_W-1:0] RSN_AVOID     = 3'd3;
  localparam logic [RSN_W-1:0] RSN_PONG      = 3'd4;
  localparam logic [RSN_W-1:0] RSN_MTU       = 3'd5;
  localparam logic [RSN_W-1:0] RSN_PRIORITY  = 3'd6;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QPTR_W-1:0] QPTR_ONE   = QPTR_W'(1);
  localparam logic [QCNT_W-1:0] QCNT_ONE   = QCNT_W'(1);
  localparam logic [QCNT_W-1:0] QCNT_FULL  = QCNT_W'(QUEUE_DEPTH);

  // one path status
  typedef struct packed {
    logic        active;
    logic        challenge_verified;
    logic [63:0] challenge_sent_time;
    logic [31:0] retransmit_timeout;
    logic [7:0]  challenge_repeats;
    logic        response_pending;
    logic [31:0] window_bytes;
    logic [31:0] inflight_bytes;
    logic        ping_pending;
    logic        mtu_probe_due;
    logic [63:0] now_time;
    logic        last_path;
  } msps_in_t;

  // decision result
  typedef struct packed {
    logic [IDX_W-1:0] selected_index;
    logic [RSN_W-1:0] reason_code;
  } msps_out_t;

  // classified path, front to back
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             judge;
    logic             challenge;
    logic             response;
    logic             verified;
    logic             uncongested;
    logic             ping;
    logic             mtu;
    logic             last;
  } msps_cls_t;

endpackage

>>> sv/msps_front.sv
`timescale 1ns / 1ps
module msps_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  msps_pkg::msps_in_t              in_data_i,
  input  logic [msps_pkg::LIMIT_W-1:0]    repeat_limit_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output msps_pkg::msps_cls_t             q_data_o
);

  logic [msps_pkg::IDX_W-1:0] position_q, position_d;
  logic                       in_range;
  logic [64:0]                timer_sum;
  logic                       expired;
  logic                       in_acc;

  assign in_ready_o = !q_full_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign q_push_o   = in_acc;

  // challenge timer, 65-bit sum so it never wraps
  assign timer_sum = {1'b0, in_data_i.challenge_sent_time}
                   + {33'b0, in_data_i.retransmit_timeout};
  assign expired   = timer_sum < {1'b0, in_data_i.now_time};
  assign in_range  = position_q < msps_pkg::MAX_PATHS_IDX;

  // classify the path
  always_comb begin
    q_data_o.idx         = position_q;
    q_data_o.judge       = in_data_i.active && in_range;
    q_data_o.challenge   = !in_data_i.challenge_verified && expired
                         && (in_data_i.challenge_repeats < repeat_limit_i);
    q_data_o.response    = in_data_i.response_pending;
    q_data_o.verified    = in_data_i.challenge_verified;
    q_data_o.uncongested = in_data_i.window_bytes > in_data_i.inflight_bytes;
    q_data_o.ping        = in_data_i.ping_pending;
    q_data_o.mtu         = in_data_i.mtu_probe_due;
    q_data_o.last        = in_data_i.last_path;
  end

  // path position within the decision
  always_comb begin
    position_d = position_q;
    if (in_acc) begin
      if (in_data_i.last_path) begin
        position_d = '0;
      end else if (in_range) begin
        position_d = position_q + msps_pkg::IDX_ONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
    end else begin
      position_q <= position_d;
    end
  end

endmodule

>>> sv/msps_queue.sv
`timescale 1ns / 1ps
module msps_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  msps_pkg::msps_cls_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output msps_pkg::msps_cls_t pop_data_o
);

  msps_pkg::msps_cls_t             mem_q [msps_pkg::QUEUE_DEPTH];
  logic [msps_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [msps_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [msps_pkg::QCNT_W-1:0]     count_q, count_d;

  assign full_o     = count_q == msps_pkg::QCNT_FULL;
  assign empty_o    = count_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + msps_pkg::QPTR_ONE;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + msps_pkg::QPTR_ONE;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + msps_pkg::QCNT_ONE;
    end else if (pop_i && !push_i) begin
      count_d = count_q - msps_pkg::QCNT_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/msps_back.sv
`timescale 1ns / 1ps
module msps_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  msps_pkg::msps_cls_t q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output msps_pkg::msps_out_t out_data_o
);

  logic                         decided_q, decided_d;
  logic [msps_pkg::IDX_W-1:0]   chosen_index_q, chosen_index_d;
  logic [msps_pkg::RSN_W-1:0]   chosen_reason_q, chosen_reason_d;
  logic                         out_valid_q, out_valid_d;
  msps_pkg::msps_out_t          out_q, out_d;
  logic                         out_free;

  // a closing record needs a free output register
  assign out_free    = !out_valid_q || out_ready_i;
  assign q_pop_o     = !q_empty_i && (!q_data_i.last || out_free);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // decision update for one popped record
  always_comb begin
    decided_d       = decided_q;
    chosen_index_d  = chosen_index_q;
    chosen_reason_d = chosen_reason_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    out_d           = out_q;
    if (q_pop_o) begin
      if (q_data_i.judge && !decided_q) begin
        if (q_data_i.challenge) begin
          decided_d       = 1'b1;
          chosen_index_d  = q_data_i.idx;
          chosen_reason_d = msps_pkg::RSN_CHALLENGE;
        end else if (q_data_i.response) begin
          decided_d       = 1'b1;
          chosen_index_d  = q_data_i.idx;
          chosen_reason_d = msps_pkg::RSN_RESPONSE;
        end else begin
          // remember the first verified path as fallback
          if (q_data_i.verified && (chosen_reason_q == msps_pkg::RSN_NONE)) begin
            chosen_index_d  = q_data_i.idx;
            chosen_reason_d = msps_pkg::RSN_AVOID;
          end
          if (q_data_i.uncongested) begin
            if (q_data_i.ping) begin
              decided_d       = 1'b1;
              chosen_index_d  = q_data_i.idx;
              chosen_reason_d = msps_pkg::RSN_PONG;
            end else if (q_data_i.mtu) begin
              decided_d       = 1'b1;
              chosen_index_d  = q_data_i.idx;
              chosen_reason_d = msps_pkg::RSN_MTU;
            end else if (q_data_i.verified) begin
              decided_d       = 1'b1;
              chosen_index_d  = q_data_i.idx;
              chosen_reason_d = msps_pkg::RSN_PRIORITY;
            end
          end
        end
      end
      // close the decision and start over
      if (q_data_i.last) begin
        out_valid_d          = 1'b1;
        out_d.selected_index = chosen_index_d;
        out_d.reason_code    = chosen_reason_d;
        decided_d            = 1'b0;
        chosen_index_d       = msps_pkg::CONTROL_INDEX;
        chosen_reason_d      = msps_pkg::RSN_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decided_q       <= 1'b0;
      chosen_index_q  <= msps_pkg::CONTROL_INDEX;
      chosen_reason_q <= msps_pkg::RSN_NONE;
      out_valid_q     <= 1'b0;
    end else begin
      decided_q       <= decided_d;
      chosen_index_q  <= chosen_index_d;
      chosen_reason_q <= chosen_reason_d;
      out_valid_q     <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // a closing record always clears the decision
  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_data_i.last |=> !decided_q && (chosen_reason_q == msps_pkg::RSN_NONE))
    else $error("decision not cleared after closing record");

  // a won decision carries a winning reason
  a_decided_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decided_q |-> (chosen_reason_q != msps_pkg::RSN_NONE)
               && (chosen_reason_q != msps_pkg::RSN_AVOID))
    else $error("decided without a winning reason");

  // no reason means the control path
  a_none_control: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chosen_reason_q == msps_pkg::RSN_NONE) |-> (chosen_index_q == msps_pkg::CONTROL_INDEX))
    else $error("path chosen without reason");

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(q_pop_o && q_data_i.last))
    else $error("closing record popped over a stalled result");

endmodule

>>> sv/multipath_send_path_selector.sv
`timescale 1ns / 1ps
// Multipath send path selector: path status items stream in one per cycle unless
// the queue is full; the item flagged last_path closes a decision and yields one
// result (selected_index, 255 for the control path, and reason_code). The front
// end classifies each path in the cycle it is accepted (timer sum and compare,
// congestion compare), a two-entry queue decouples it from the back end, which
// updates the decision one record per cycle unless a closing record waits on a
// busy output register; without stalls the sustained rate is one item per cycle.
// The result goes to an output register once the closing item leaves the queue,
// so a new decision streams in while it waits. The cfg write port (repeat limit)
// is always ready and must only be written while no decision is in progress.
module multipath_send_path_selector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [msps_pkg::LIMIT_W-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  msps_pkg::msps_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output msps_pkg::msps_out_t          out_data_o
);

  logic [msps_pkg::LIMIT_W-1:0] repeat_limit_q;
  logic                         q_full;
  logic                         q_empty;
  logic                         q_push;
  logic                         q_pop;
  msps_pkg::msps_cls_t          q_wdata;
  msps_pkg::msps_cls_t          q_rdata;

  // repeat limit register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_limit_q <= msps_pkg::REPEAT_LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      repeat_limit_q <= cfg_data_i;
    end
  end

  msps_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .repeat_limit_i (repeat_limit_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata)
  );

  msps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  msps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
